// File: design/lilst_pkg.sv
// Package for the indexed list store: request and status codes, cell command
// type and sizing constants. No dependencies; used by every design file.
`default_nettype none
package lilst_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   // Position width that covers the largest supported capacity (4096 entries).
   localparam int POS_W   = 12;
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 10;
   localparam int FUNC_W  = 3;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 11;
   // Entries combined in each first-level group of the read tree.
   localparam int READ_GROUP = 32;

   typedef enum logic [FUNC_W-1:0] {
      FN_GET      = 3'd0,
      FN_ADD_HEAD = 3'd1,
      FN_ADD_TAIL = 3'd2,
      FN_ADD_AT   = 3'd3,
      FN_DELETE   = 3'd4
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   pos;
      logic [DATA_W-1:0]  value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE,
      ST_RESP
   } fsm_state_type;

endpackage
`default_nettype wire

// File: design/lilst_cell.sv
// One storage cell of the list: holds the entry at a fixed position and
// shifts with its neighbours on insert and delete. Depends on lilst_pkg.
`default_nettype none
module lilst_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                         clock,
   input  wire lilst_pkg::cell_cmd_type      cmd,
   input  wire logic [lilst_pkg::DATA_W-1:0] left_data,
   input  wire logic [lilst_pkg::DATA_W-1:0] right_data,
   output logic      [lilst_pkg::DATA_W-1:0] data,
   output logic      [lilst_pkg::DATA_W-1:0] rd_data
);
   import lilst_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_pos;
   logic              above;

   assign at_pos = (cmd.pos == MY_POS);
   assign above  = (MY_POS > cmd.pos);

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (above) begin
               data_in = left_data;
            end else if (at_pos) begin
               data_in = cmd.value;
            end
         end
         CELL_DELETE: begin
            if (above || at_pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   // Only the addressed cell contributes to the read tree.
   assign rd_data = at_pos ? data_ff : '0;

endmodule
`default_nettype wire

// File: design/lilst_read_tree.sv
// Two-level registered OR tree that gathers the one addressed entry from
// the row of cells. Depends on lilst_pkg.
`default_nettype none
module lilst_read_tree #(
   parameter int CAPACITY = lilst_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         group_en,
   input  wire logic                         sum_en,
   input  wire logic [lilst_pkg::DATA_W-1:0] leaf [CAPACITY],
   output logic      [lilst_pkg::DATA_W-1:0] sum
);
   import lilst_pkg::*;

   localparam int NUM_GROUPS = (CAPACITY + READ_GROUP - 1) / READ_GROUP;

   logic [DATA_W-1:0] group_ff [NUM_GROUPS];
   logic [DATA_W-1:0] group_in [NUM_GROUPS];
   logic [DATA_W-1:0] sum_ff;
   logic [DATA_W-1:0] sum_in;

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      always_comb begin
         group_in[g] = '0;
         for (int k = 0; k < READ_GROUP; k++) begin
            if (g * READ_GROUP + k < CAPACITY) begin
               group_in[g] = group_in[g] | leaf[g * READ_GROUP + k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (group_en) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sum_in = sum_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule
`default_nettype wire

// File: design/indexed_list_insert_delete_top.sv
// Indexed list store: a row of CAPACITY cells that shift on insert/delete.
// After a request beat is accepted the sequencer runs EXEC (cell shift and
// group read), REDUCE (final read) and RESP, where rsp_tvalid is held until
// the response is taken; only then can the next request be accepted.
// Reset (synchronous, active high) empties the list; entry contents are
// not cleared, as only positions below the length are ever read.
`default_nettype none
module indexed_list_insert_delete_top #(
   parameter int CAPACITY = lilst_pkg::CAPACITY_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] func, [12:3] index, [44:13] value, [47:45] zero
   input  wire logic [47:0] req_tdata,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] read_value, [33:32] status, [44:34] length, [47:45] zero
   output logic [47:0]      rsp_tdata
);
   import lilst_pkg::*;

   // Width of the entry count, which must hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Common width for comparing the request index against the count.
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   // Request fields as they arrive on the bus.
   logic [FUNC_W-1:0]  req_func;
   logic [INDEX_W-1:0] req_index;
   logic [DATA_W-1:0]  req_value;

   assign req_func  = req_tdata[2:0];
   assign req_index = req_tdata[12:3];
   assign req_value = req_tdata[44:13];

   // Control state.
   fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Decoded request, held for the cells and the response.
   cell_cmd_type cmd_ff, cmd_in;
   status_type   status_ff, status_in;
   logic         rd_ok_ff, rd_ok_in;

   logic accept;
   logic rsp_done;

   assign accept   = req_tvalid && req_tready;
   assign rsp_done = rsp_tvalid && rsp_tready;

   // The decision is made once, at the request beat, against the current
   // length. Rejected requests leave the cells holding and the count as it is.
   logic [CMP_W-1:0] idx_w;
   logic [CMP_W-1:0] cnt_w;
   logic             is_full;

   assign idx_w   = CMP_W'(req_index);
   assign cnt_w   = CMP_W'(count_ff);
   assign is_full = (cnt_w >= CMP_W'(CAPACITY));

   always_comb begin
      cmd_in.op    = CELL_HOLD;
      cmd_in.pos   = POS_W'(idx_w);
      cmd_in.value = req_value;
      status_in    = STAT_DONE;
      rd_ok_in     = 1'b0;
      count_in     = count_ff;
      unique case (req_func)
         FN_GET: begin
            if (idx_w < cnt_w) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = STAT_RANGE;
            end
         end
         FN_ADD_HEAD: begin
            cmd_in.pos = '0;
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               cmd_in.op = CELL_INSERT;
               count_in  = count_ff + 1'b1;
            end
         end
         FN_ADD_TAIL: begin
            cmd_in.pos = POS_W'(cnt_w);
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               cmd_in.op = CELL_INSERT;
               count_in  = count_ff + 1'b1;
            end
         end
         FN_ADD_AT: begin
            // The range check takes precedence over the full check.
            if (idx_w > cnt_w) begin
               status_in = STAT_RANGE;
            end else if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               cmd_in.op = CELL_INSERT;
               count_in  = count_ff + 1'b1;
            end
         end
         FN_DELETE: begin
            if (idx_w >= cnt_w) begin
               status_in = STAT_RANGE;
            end else begin
               cmd_in.op = CELL_DELETE;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            // Unused function codes change nothing and report done.
            status_in = STAT_DONE;
         end
      endcase
   end

   // Next-state logic of the control sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decode of the sequencer.
   logic         group_en;
   logic         sum_en;
   cell_cmd_type cell_cmd;

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      group_en     = 1'b0;
      sum_en       = 1'b0;
      cell_cmd     = cmd_ff;
      cell_cmd.op  = CELL_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EXEC: begin
            // Cells apply the shift while the group stage samples the
            // addressed entry; a read never shifts, so it sees the old data.
            cell_cmd.op = cmd_ff.op;
            group_en    = 1'b1;
         end
         ST_REDUCE: begin
            sum_en = 1'b1;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   // The row of cells. Each cell sees its lower and upper neighbour; the
   // ends take zero, which only ever lands beyond the current length.
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_rd   [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      lilst_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   logic [DATA_W-1:0] rd_sum;

   lilst_read_tree #(
      .CAPACITY (CAPACITY)
   ) u_read_tree (
      .clock    (clock),
      .group_en (group_en),
      .sum_en   (sum_en),
      .leaf     (cell_rd),
      .sum      (rd_sum)
   );

   // Response beat: all fields come from registers that hold while waiting.
   logic [DATA_W-1:0] rsp_read_value;

   assign rsp_read_value = rd_ok_ff ? rd_sum : '0;
   assign rsp_tdata      = {3'b000, LEN_W'(count_ff), status_ff, rsp_read_value};

endmodule
`default_nettype wire
